>>> design/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned THREAD_SLOTS_DEF = 16;
  localparam int unsigned RT_W = 31;

  localparam logic [31:0] FRAME_BYTES = 32'd64;

  localparam logic [31:0] STACK_TOP_RST  = 32'h0001_6000;
  localparam logic [16:0] STACK_SIZE_RST = 17'h0_1000;
  localparam logic [31:0] IDLE_TOP_RST   = 32'h0000_5000;
  localparam logic [15:0] TICK_RST       = 16'd1;

  typedef enum logic [1:0] {
    REG_STACK_TOP,
    REG_STACK_SIZE,
    REG_IDLE_TOP,
    REG_TICK_PERIOD
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_DELETE,
    OP_SLEEP,
    OP_WAKE,
    OP_BLOCK,
    OP_TICK,
    OP_SWITCH
  } op_e;

  typedef enum logic [2:0] {
    T_READY,
    T_RUNNING,
    T_TERMINATED,
    T_SLEEPING,
    T_BLOCKED
  } tstate_e;

  typedef enum logic [1:0] {
    STAT_DONE,
    STAT_NOFREE,
    STAT_NOCHANGE
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_FIND,
    S_SW_NONE,
    S_CALC,
    S_CREATE,
    S_SP_READ,
    S_TICK_RD,
    S_TICK_WR,
    S_DONE
  } ctl_state_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SIMPLE,
    CMD_NOCHANGE,
    CMD_WALK_INIT,
    CMD_TICK_INIT,
    CMD_STEP,
    CMD_CREATE_ZERO,
    CMD_CREATE_HIT,
    CMD_NOFREE,
    CMD_SW_HIT,
    CMD_SW_NONE,
    CMD_CALC,
    CMD_CREATE_WR,
    CMD_SP_CAPTURE,
    CMD_TICK_WR,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic use_idx;
  } ctl_t;

  typedef struct packed {
    logic is_create;
    logic is_switch;
    logic is_tick;
    logic live_zero;
    logic walk_done;
    logic walk_last;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

>>> design/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Each word is one scheduler operation and returns exactly one result word.
// Sleep, wake, delete, block and unknown operations go from acceptance through
// the start and done states to a result in the output register. Create and
// switch walk the thread table one slot per cycle; tick reads the remaining
// time of every slot from the timer RAM, whose read data is registered, and
// writes the updated time back for blocked slots, in a read state and a write
// state per slot.
// A new word is accepted once the previous one has reached the output
// register, even if that result has not yet been taken.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int unsigned ThreadSlots = rrts_pkg::THREAD_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  in_op_i,
  input  logic [3:0]  in_target_thread_i,
  input  logic [31:0] in_saved_sp_i,
  input  logic [30:0] in_wait_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_status_o,
  output logic [3:0]  out_slot_o,
  output logic        out_load_sp_o,
  output logic [31:0] out_new_sp_o,
  output logic        out_has_current_o
);

  rrts_pkg::ctl_t ctl;
  rrts_pkg::sts_t sts;

  rrts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  rrts_dpath #(.ThreadSlots(ThreadSlots)) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_op_i           (in_op_i),
    .in_target_thread_i(in_target_thread_i),
    .in_saved_sp_i     (in_saved_sp_i),
    .in_wait_time_i    (in_wait_time_i),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .out_status_o      (out_status_o),
    .out_slot_o        (out_slot_o),
    .out_load_sp_o     (out_load_sp_o),
    .out_new_sp_o      (out_new_sp_o),
    .out_has_current_o (out_has_current_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("scheduler accepted a word while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_load_sp_o) |-> (out_status_o == rrts_pkg::STAT_DONE))
    else $error("stack load without a completed operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o != rrts_pkg::STAT_DONE)) |->
    ((out_slot_o == 4'd0) && (out_new_sp_o == 32'd0)))
    else $error("failed operation returned slot or stack data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.cmd == rrts_pkg::CMD_EMIT) |=> out_valid_o)
    else $error("result lost at hand-off");
`endif

endmodule

>>> design/rrts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one word through decode, table walks, writes and result hand-off.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rrts_pkg::sts_t sts_i,
  output rrts_pkg::ctl_t ctl_o
);

  rrts_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    ctl_o.cmd     = rrts_pkg::CMD_NONE;
    ctl_o.use_idx = 1'b0;
    in_ready_o    = 1'b0;
    case (state_q)
      rrts_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.cmd = rrts_pkg::CMD_LOAD;
          state_d   = rrts_pkg::S_START;
        end
      end
      rrts_pkg::S_START: begin
        if (sts_i.is_create) begin
          if (sts_i.live_zero) begin
            ctl_o.cmd = rrts_pkg::CMD_CREATE_ZERO;
            state_d   = rrts_pkg::S_CALC;
          end else begin
            ctl_o.cmd = rrts_pkg::CMD_WALK_INIT;
            state_d   = rrts_pkg::S_FIND;
          end
        end else if (sts_i.is_switch) begin
          if (sts_i.live_zero) begin
            ctl_o.cmd = rrts_pkg::CMD_NOCHANGE;
            state_d   = rrts_pkg::S_DONE;
          end else begin
            ctl_o.cmd = rrts_pkg::CMD_WALK_INIT;
            state_d   = rrts_pkg::S_FIND;
          end
        end else if (sts_i.is_tick) begin
          if (sts_i.live_zero) begin
            ctl_o.cmd = rrts_pkg::CMD_NOCHANGE;
            state_d   = rrts_pkg::S_DONE;
          end else begin
            ctl_o.cmd = rrts_pkg::CMD_TICK_INIT;
            state_d   = rrts_pkg::S_TICK_RD;
          end
        end else begin
          ctl_o.cmd = rrts_pkg::CMD_SIMPLE;
          state_d   = rrts_pkg::S_DONE;
        end
      end
      rrts_pkg::S_FIND: begin
        ctl_o.use_idx = 1'b1;
        if (sts_i.walk_done) begin
          if (sts_i.is_create) begin
            ctl_o.cmd = rrts_pkg::CMD_NOFREE;
            state_d   = rrts_pkg::S_DONE;
          end else begin
            state_d = rrts_pkg::S_SW_NONE;
          end
        end else if (sts_i.hit) begin
          if (sts_i.is_create) begin
            ctl_o.cmd = rrts_pkg::CMD_CREATE_HIT;
            state_d   = rrts_pkg::S_CALC;
          end else begin
            ctl_o.cmd = rrts_pkg::CMD_SW_HIT;
            state_d   = rrts_pkg::S_SP_READ;
          end
        end else begin
          ctl_o.cmd = rrts_pkg::CMD_STEP;
        end
      end
      rrts_pkg::S_SW_NONE: begin
        ctl_o.cmd = rrts_pkg::CMD_SW_NONE;
        state_d   = rrts_pkg::S_DONE;
      end
      rrts_pkg::S_CALC: begin
        ctl_o.cmd = rrts_pkg::CMD_CALC;
        state_d   = rrts_pkg::S_CREATE;
      end
      rrts_pkg::S_CREATE: begin
        ctl_o.cmd = rrts_pkg::CMD_CREATE_WR;
        state_d   = rrts_pkg::S_DONE;
      end
      rrts_pkg::S_SP_READ: begin
        ctl_o.cmd = rrts_pkg::CMD_SP_CAPTURE;
        state_d   = rrts_pkg::S_DONE;
      end
      rrts_pkg::S_TICK_RD: begin
        state_d = rrts_pkg::S_TICK_WR;
      end
      rrts_pkg::S_TICK_WR: begin
        ctl_o.use_idx = 1'b1;
        ctl_o.cmd     = rrts_pkg::CMD_TICK_WR;
        state_d       = sts_i.walk_last ? rrts_pkg::S_DONE : rrts_pkg::S_TICK_RD;
      end
      rrts_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.cmd = rrts_pkg::CMD_EMIT;
          state_d   = rrts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rrts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> design/rrts_dpath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Thread table, stack and timer RAMs, configuration and result registers.
// ----------------------------------------------------------------------------
module rrts_dpath #(
  parameter int unsigned ThreadSlots = rrts_pkg::THREAD_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  input  logic [2:0]     in_op_i,
  input  logic [3:0]     in_target_thread_i,
  input  logic [31:0]    in_saved_sp_i,
  input  logic [30:0]    in_wait_time_i,
  input  rrts_pkg::ctl_t ctl_i,
  output rrts_pkg::sts_t sts_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [1:0]     out_status_o,
  output logic [3:0]     out_slot_o,
  output logic           out_load_sp_o,
  output logic [31:0]    out_new_sp_o,
  output logic           out_has_current_o
);

  localparam int unsigned SlotW = $clog2(ThreadSlots);
  localparam int unsigned CntW  = $clog2(ThreadSlots + 1);
  localparam int unsigned ProdW = SlotW + 17;
  localparam int unsigned RtW   = rrts_pkg::RT_W;

  logic [31:0] top_q, top_d, idle_q, idle_d;
  logic [16:0] size_q, size_d;
  logic [15:0] period_q, period_d;

  rrts_pkg::tstate_e tstate_q [ThreadSlots];
  logic                 st_we;
  logic [SlotW-1:0]     st_waddr;
  rrts_pkg::tstate_e    st_wdata;

  logic [SlotW-1:0] cur_q, cur_d, idx_q, idx_d, fslot_q, fslot_d;
  logic             cur_valid_q, cur_valid_d;
  logic [CntW-1:0]  live_q, live_d, cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  logic [2:0]       op_q, op_d;
  logic [3:0]       target_q, target_d;
  logic [31:0]      saved_q, saved_d;
  logic [RtW-1:0]   btime_q, btime_d;
  logic [ProdW-1:0] prod_q, prod_d;

  rrts_pkg::status_e res_status_q, res_status_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  logic              res_load_q, res_load_d;
  logic [31:0]       res_sp_q, res_sp_d;

  logic [1:0]  out_status_q, out_status_d;
  logic [3:0]  out_slot_q, out_slot_d;
  logic        out_load_q, out_load_d;
  logic [31:0] out_sp_q, out_sp_d;
  logic        out_cur_q, out_cur_d;

  logic             sp_we, rt_we;
  logic [SlotW-1:0] sp_waddr, rt_waddr;
  logic [31:0]      sp_wdata, sp_rdata, create_sp;
  logic [RtW-1:0]   rt_wdata, rt_rdata;

  logic              tgt_in_range, is_target_op, cur_live;
  logic [SlotW-1:0]  tgt_idx, rd_addr, idx_inc, cur_inc;
  rrts_pkg::tstate_e st_rd;

  rrts_ram #(.Width(32), .Depth(ThreadSlots)) u_sp_ram (
    .clk_i  (clk_i),
    .we_i   (sp_we),
    .waddr_i(sp_waddr),
    .wdata_i(sp_wdata),
    .raddr_i(idx_q),
    .rdata_o(sp_rdata)
  );

  rrts_ram #(.Width(RtW), .Depth(ThreadSlots)) u_rt_ram (
    .clk_i  (clk_i),
    .we_i   (rt_we),
    .waddr_i(rt_waddr),
    .wdata_i(rt_wdata),
    .raddr_i(idx_q),
    .rdata_o(rt_rdata)
  );

  always_comb begin
    tgt_in_range = 32'(target_q) < 32'(ThreadSlots);
    tgt_idx      = tgt_in_range ? SlotW'(target_q) : '0;
    is_target_op = (op_q == rrts_pkg::OP_SLEEP) || (op_q == rrts_pkg::OP_WAKE);
    if (ctl_i.use_idx) begin
      rd_addr = idx_q;
    end else if (is_target_op) begin
      rd_addr = tgt_idx;
    end else begin
      rd_addr = cur_q;
    end
    st_rd    = tstate_q[rd_addr];
    cur_live = cur_valid_q && (st_rd != rrts_pkg::T_TERMINATED);
    idx_inc  = (idx_q == SlotW'(ThreadSlots - 1)) ? '0 : idx_q + SlotW'(1);
    cur_inc  = (cur_q == SlotW'(ThreadSlots - 1)) ? '0 : cur_q + SlotW'(1);
    create_sp = top_q - 32'(prod_q) - rrts_pkg::FRAME_BYTES;
  end

  always_comb begin
    sts_o.is_create = op_q == rrts_pkg::OP_CREATE;
    sts_o.is_switch = op_q == rrts_pkg::OP_SWITCH;
    sts_o.is_tick   = op_q == rrts_pkg::OP_TICK;
    sts_o.live_zero = live_q == '0;
    sts_o.walk_done = cnt_q == '0;
    sts_o.walk_last = cnt_q == CntW'(1);
    sts_o.hit       = (op_q == rrts_pkg::OP_CREATE) ? (st_rd == rrts_pkg::T_TERMINATED)
                    : ((st_rd == rrts_pkg::T_READY) || (st_rd == rrts_pkg::T_RUNNING));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    top_d        = top_q;
    size_d       = size_q;
    idle_d       = idle_q;
    period_d     = period_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    live_d       = live_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    fslot_d      = fslot_q;
    prod_d       = prod_q;
    op_d         = op_q;
    target_d     = target_q;
    saved_d      = saved_q;
    btime_d      = btime_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_load_d   = res_load_q;
    res_sp_d     = res_sp_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_load_d   = out_load_q;
    out_sp_d     = out_sp_q;
    out_cur_d    = out_cur_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    st_we        = 1'b0;
    st_waddr     = cur_q;
    st_wdata     = rrts_pkg::T_TERMINATED;
    sp_we        = 1'b0;
    sp_waddr     = cur_q;
    sp_wdata     = saved_q;
    rt_we        = 1'b0;
    rt_waddr     = cur_q;
    rt_wdata     = btime_q;

    if (cfg_we_i) begin
      case (rrts_pkg::cfg_reg_e'(cfg_idx_i))
        rrts_pkg::REG_STACK_TOP:   top_d    = cfg_data_i;
        rrts_pkg::REG_STACK_SIZE:  size_d   = cfg_data_i[16:0];
        rrts_pkg::REG_IDLE_TOP:    idle_d   = cfg_data_i;
        rrts_pkg::REG_TICK_PERIOD: period_d = cfg_data_i[15:0];
        default: ;
      endcase
    end

    case (ctl_i.cmd)
      rrts_pkg::CMD_LOAD: begin
        op_d         = in_op_i;
        target_d     = in_target_thread_i;
        saved_d      = in_saved_sp_i;
        btime_d      = in_wait_time_i;
        res_status_d = rrts_pkg::STAT_NOCHANGE;
        res_slot_d   = '0;
        res_load_d   = 1'b0;
        res_sp_d     = '0;
      end
      rrts_pkg::CMD_SIMPLE: begin
        case (op_q)
          rrts_pkg::OP_DELETE: begin
            if (cur_live) begin
              st_we        = 1'b1;
              st_wdata     = rrts_pkg::T_TERMINATED;
              if (live_q != '0) begin
                live_d = live_q - CntW'(1);
              end
              if (live_q <= CntW'(1)) begin
                cur_valid_d = 1'b0;
              end
              res_slot_d   = cur_q;
              res_load_d   = 1'b1;
              res_sp_d     = idle_q;
              res_status_d = rrts_pkg::STAT_DONE;
            end
          end
          rrts_pkg::OP_SLEEP, rrts_pkg::OP_WAKE: begin
            if (tgt_in_range && (st_rd != rrts_pkg::T_TERMINATED)) begin
              st_we        = 1'b1;
              st_waddr     = tgt_idx;
              st_wdata     = (op_q == rrts_pkg::OP_SLEEP) ? rrts_pkg::T_SLEEPING
                                                         : rrts_pkg::T_RUNNING;
              res_status_d = rrts_pkg::STAT_DONE;
            end
          end
          rrts_pkg::OP_BLOCK: begin
            if (cur_live) begin
              st_we        = 1'b1;
              st_wdata     = rrts_pkg::T_BLOCKED;
              rt_we        = 1'b1;
              res_status_d = rrts_pkg::STAT_DONE;
            end
          end
          default: ;
        endcase
      end
      rrts_pkg::CMD_WALK_INIT: begin
        if (cur_valid_q) begin
          idx_d = cur_inc;
          cnt_d = CntW'(ThreadSlots - 1);
        end else begin
          idx_d = '0;
          cnt_d = CntW'(ThreadSlots);
        end
      end
      rrts_pkg::CMD_TICK_INIT: begin
        idx_d        = '0;
        cnt_d        = CntW'(ThreadSlots);
        res_status_d = rrts_pkg::STAT_DONE;
      end
      rrts_pkg::CMD_STEP: begin
        idx_d = idx_inc;
        cnt_d = cnt_q - CntW'(1);
      end
      rrts_pkg::CMD_CREATE_ZERO: begin
        fslot_d = '0;
      end
      rrts_pkg::CMD_CREATE_HIT: begin
        fslot_d = idx_q;
      end
      rrts_pkg::CMD_NOFREE: begin
        res_status_d = rrts_pkg::STAT_NOFREE;
      end
      rrts_pkg::CMD_SW_HIT: begin
        sp_we = cur_valid_q;
        if (st_rd == rrts_pkg::T_READY) begin
          st_we    = 1'b1;
          st_waddr = idx_q;
          st_wdata = rrts_pkg::T_RUNNING;
        end
        cur_d        = idx_q;
        cur_valid_d  = 1'b1;
        res_slot_d   = idx_q;
        res_load_d   = 1'b1;
        res_status_d = rrts_pkg::STAT_DONE;
      end
      rrts_pkg::CMD_SW_NONE: begin
        if (cur_valid_q && ((st_rd == rrts_pkg::T_SLEEPING) ||
                            (st_rd == rrts_pkg::T_BLOCKED))) begin
          sp_we        = 1'b1;
          cur_valid_d  = 1'b0;
          res_load_d   = 1'b1;
          res_sp_d     = idle_q - rrts_pkg::FRAME_BYTES;
          res_status_d = rrts_pkg::STAT_DONE;
        end
      end
      rrts_pkg::CMD_CALC: begin
        prod_d = ProdW'(fslot_q) * ProdW'(size_q);
      end
      rrts_pkg::CMD_CREATE_WR: begin
        st_we        = 1'b1;
        st_waddr     = fslot_q;
        st_wdata     = rrts_pkg::T_READY;
        rt_we        = 1'b1;
        rt_waddr     = fslot_q;
        rt_wdata     = '0;
        sp_we        = 1'b1;
        sp_waddr     = fslot_q;
        sp_wdata     = create_sp;
        live_d       = live_q + CntW'(1);
        res_slot_d   = fslot_q;
        res_sp_d     = create_sp;
        res_status_d = rrts_pkg::STAT_DONE;
      end
      rrts_pkg::CMD_SP_CAPTURE: begin
        res_sp_d = sp_rdata;
      end
      rrts_pkg::CMD_TICK_WR: begin
        if (st_rd == rrts_pkg::T_BLOCKED) begin
          rt_we    = 1'b1;
          rt_waddr = idx_q;
          if (rt_rdata <= RtW'(period_q)) begin
            st_we    = 1'b1;
            st_waddr = idx_q;
            st_wdata = rrts_pkg::T_RUNNING;
            rt_wdata = '0;
          end else begin
            rt_wdata = rt_rdata - RtW'(period_q);
          end
        end
        idx_d = idx_inc;
        cnt_d = cnt_q - CntW'(1);
      end
      rrts_pkg::CMD_EMIT: begin
        out_valid_d  = 1'b1;
        out_status_d = res_status_q;
        out_slot_d   = 4'(res_slot_q);
        out_load_d   = res_load_q;
        out_sp_d     = res_sp_q;
        out_cur_d    = cur_valid_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= rrts_pkg::STACK_TOP_RST;
      size_q      <= rrts_pkg::STACK_SIZE_RST;
      idle_q      <= rrts_pkg::IDLE_TOP_RST;
      period_q    <= rrts_pkg::TICK_RST;
      for (int i = 0; i < ThreadSlots; i++) begin
        tstate_q[i] <= rrts_pkg::T_TERMINATED;
      end
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      live_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      top_q       <= top_d;
      size_q      <= size_d;
      idle_q      <= idle_d;
      period_q    <= period_d;
      if (st_we) begin
        tstate_q[st_waddr] <= st_wdata;
      end
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      live_q      <= live_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fslot_q      <= fslot_d;
    prod_q       <= prod_d;
    op_q         <= op_d;
    target_q     <= target_d;
    saved_q      <= saved_d;
    btime_q      <= btime_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_load_q   <= res_load_d;
    res_sp_q     <= res_sp_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_load_q   <= out_load_d;
    out_sp_q     <= out_sp_d;
    out_cur_q    <= out_cur_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_slot_o        = out_slot_q;
  assign out_load_sp_o     = out_load_q;
  assign out_new_sp_o      = out_sp_q;
  assign out_has_current_o = out_cur_q;

endmodule

>>> tb/round_robin_thread_scheduler_test.sv
// ----------------------------------------------------------------------------
// Round-robin thread scheduler testbench
// Drives scheduler operations through the input channel and compares every
// result word with a predictor of the thread table, over several register
// settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_test;
  import rrts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = THREAD_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  target;
    logic [31:0] saved_sp;
    logic [30:0] wait_time;
  } sched_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        load_sp;
    logic [31:0] new_sp;
    logic        has_current;
  } sched_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  in_op_i = '0;
  logic [3:0]  in_target_thread_i = '0;
  logic [31:0] in_saved_sp_i = '0;
  logic [30:0] in_wait_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  out_status_o;
  logic [3:0]  out_slot_o;
  logic        out_load_sp_o;
  logic [31:0] out_new_sp_o;
  logic        out_has_current_o;

  round_robin_thread_scheduler u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_op_i, .in_target_thread_i, .in_saved_sp_i,
    .in_wait_time_i, .out_valid_o, .out_ready_i, .out_status_o, .out_slot_o,
    .out_load_sp_o, .out_new_sp_o, .out_has_current_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state.
  logic [31:0] m_stack_top, m_idle_top;
  logic [16:0] m_stack_size;
  logic [15:0] m_tick;
  tstate_e     m_state [NSLOT];
  logic [31:0] m_sp [NSLOT];
  logic [31:0] m_remain [NSLOT];
  logic [3:0]  m_cur;
  logic        m_cur_valid;
  int unsigned m_live;

  sched_cmd_t  pending_cmds[$];
  sched_res_t  expected_results[$];
  logic        calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  function automatic int find_slot(input logic want_free);
    int unsigned i, count;
    i = m_cur_valid ? (m_cur + 1) % NSLOT : 0;
    count = m_cur_valid ? NSLOT - 1 : NSLOT;
    for (int unsigned n = 0; n < count; n++) begin
      if (want_free ? (m_state[i] == T_TERMINATED)
                    : (m_state[i] == T_READY || m_state[i] == T_RUNNING)) return int'(i);
      i = (i + 1) % NSLOT;
    end
    return -1;
  endfunction

  function automatic sched_res_t schedule_step(input sched_cmd_t c);
    sched_res_t r;
    int f;
    logic cur_live;
    r = '0;
    r.status = STAT_NOCHANGE;
    cur_live = m_cur_valid && m_state[m_cur] != T_TERMINATED;
    case (c.op)
      OP_CREATE: begin
        f = (m_live == 0) ? 0 : find_slot(1'b1);
        if (f < 0) begin
          r.status = STAT_NOFREE;
        end else begin
          r.slot = 4'(f);
          r.new_sp = m_stack_top - 32'(f) * 32'(m_stack_size) - FRAME_BYTES;
          m_state[f] = T_READY;
          m_remain[f] = '0;
          m_sp[f] = r.new_sp;
          m_live++;
          r.status = STAT_DONE;
        end
      end
      OP_DELETE: begin
        if (cur_live) begin
          m_state[m_cur] = T_TERMINATED;
          if (m_live > 0) m_live--;
          r.slot = m_cur;
          if (m_live == 0) m_cur_valid = 1'b0;
          r.load_sp = 1'b1;
          r.new_sp = m_idle_top;
          r.status = STAT_DONE;
        end
      end
      OP_SLEEP, OP_WAKE: begin
        if (m_state[c.target] != T_TERMINATED) begin
          m_state[c.target] = (c.op == OP_SLEEP) ? T_SLEEPING : T_RUNNING;
          r.status = STAT_DONE;
        end
      end
      OP_BLOCK: begin
        if (cur_live) begin
          m_state[m_cur] = T_BLOCKED;
          m_remain[m_cur] = {1'b0, c.wait_time};
          r.status = STAT_DONE;
        end
      end
      OP_TICK: begin
        if (m_live != 0) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (m_state[i] == T_BLOCKED) begin
              if (m_remain[i] <= 32'(m_tick)) begin
                m_state[i] = T_RUNNING;
                m_remain[i] = '0;
              end else begin
                m_remain[i] -= 32'(m_tick);
              end
            end
          end
          r.status = STAT_DONE;
        end
      end
      OP_SWITCH: begin
        if (m_live != 0) begin
          f = find_slot(1'b0);
          if (f >= 0) begin
            if (m_cur_valid) m_sp[m_cur] = c.saved_sp;
            r.new_sp = m_sp[f];
            r.load_sp = 1'b1;
            if (m_state[f] == T_READY) m_state[f] = T_RUNNING;
            m_cur = 4'(f);
            m_cur_valid = 1'b1;
            r.slot = 4'(f);
            r.status = STAT_DONE;
          end else if (m_cur_valid &&
                       (m_state[m_cur] == T_SLEEPING || m_state[m_cur] == T_BLOCKED)) begin
            m_sp[m_cur] = c.saved_sp;
            r.new_sp = m_idle_top - FRAME_BYTES;
            r.load_sp = 1'b1;
            m_cur_valid = 1'b0;
            r.status = STAT_DONE;
          end
        end
      end
      default: ;
    endcase
    r.has_current = m_cur_valid;
    return r;
  endfunction

  // Driver: the predictor runs on acceptance.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_results.push_back(schedule_step(
          {in_op_i, in_target_thread_i, in_saved_sp_i, in_wait_time_i}));
    end
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
        sched_cmd_t c;
        c = pending_cmds.pop_front();
        in_valid_i <= 1'b1;
        in_op_i <= c.op;
        in_target_thread_i <= c.target;
        in_saved_sp_i <= c.saved_sp;
        in_wait_time_i <= c.wait_time;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      sched_res_t got, want;
      got = {out_status_o, out_slot_o, out_load_sp_o, out_new_sp_o, out_has_current_o};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d slot=%0d ld=%0b sp=%h cur=%0b",
                   $time, want.status, want.slot, want.load_sp, want.new_sp,
                   want.has_current);
          $display("%0t:          actual st=%0d slot=%0d ld=%0b sp=%h cur=%0b",
                   $time, got.status, got.slot, got.load_sp, got.new_sp,
                   got.has_current);
          error_count++;
        end
      end
    end
    out_ready_i <= rst_ni && (calm || $urandom_range(99) >= 32);
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_STACK_TOP:  m_stack_top = val;
      REG_STACK_SIZE: m_stack_size = val[16:0];
      REG_IDLE_TOP:   m_idle_top = val;
      default:        m_tick = val[15:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_cmd(input op_e op, input logic [3:0] tgt,
                         input logic [31:0] sp, input logic [30:0] bt);
    pending_cmds.push_back({op, tgt, sp, bt});
  endtask

  function automatic logic [30:0] rand_btime();
    case ($urandom_range(3))
      0: return 31'($urandom_range(3));
      1: return 31'($urandom_range(40));
      2: return 31'($urandom);
      default: return 31'h7fffffff;
    endcase
  endfunction

  task automatic add_random(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      int unsigned p;
      op_e op;
      p = $urandom_range(99);
      if (p < 18) op = OP_CREATE;
      else if (p < 26) op = OP_DELETE;
      else if (p < 36) op = OP_SLEEP;
      else if (p < 46) op = OP_WAKE;
      else if (p < 56) op = OP_BLOCK;
      else if (p < 72) op = OP_TICK;
      else if (p < 98) op = OP_SWITCH;
      else op = op_e'(3'd7);
      add_cmd(op, 4'($urandom), $urandom, rand_btime());
    end
  endtask

  task automatic run_phase();
    while (pending_cmds.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (2 * NSLOT + 10) @(posedge clk_i);
  endtask

  initial begin
    m_stack_top = STACK_TOP_RST;
    m_stack_size = STACK_SIZE_RST;
    m_idle_top = IDLE_TOP_RST;
    m_tick = TICK_RST;
    foreach (m_state[i]) begin
      m_state[i] = T_TERMINATED;
      m_sp[i] = '0;
      m_remain[i] = '0;
    end
    m_cur = '0;
    m_cur_valid = 1'b0;
    m_live = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Operations on an empty table, then a full table and its edge cases.
    add_cmd(OP_DELETE, 4'd0, '0, '0);
    add_cmd(OP_SWITCH, 4'd0, 32'hffffffff, '0);
    add_cmd(OP_TICK, 4'd0, '0, '0);
    add_cmd(OP_SLEEP, 4'd15, '0, '0);
    add_cmd(OP_BLOCK, 4'd0, '0, 31'h7fffffff);
    add_cmd(op_e'(3'd7), 4'hf, 32'hffffffff, 31'h7fffffff);
    for (int i = 0; i < NSLOT + 1; i++) add_cmd(OP_CREATE, 4'(i), '0, '0);
    add_cmd(OP_SWITCH, 4'd0, 32'h0, '0);
    add_cmd(OP_BLOCK, 4'd0, '0, 31'd2);
    add_cmd(OP_SLEEP, 4'd1, '0, '0);
    add_cmd(OP_WAKE, 4'd1, '0, '0);
    add_cmd(OP_TICK, 4'd0, '0, '0);
    add_cmd(OP_TICK, 4'd0, '0, '0);
    add_cmd(OP_SWITCH, 4'd0, 32'hffffffff, '0);
    add_cmd(OP_DELETE, 4'd0, '0, '0);
    run_phase();

    // The random part runs in phases with different register settings.
    calm = 1'b1;
    add_random(60);
    run_phase();
    calm = 1'b0;
    write_reg(REG_STACK_TOP, 32'h0);
    write_reg(REG_STACK_SIZE, 32'd64);
    write_reg(REG_IDLE_TOP, 32'h0);
    write_reg(REG_TICK_PERIOD, 32'd65535);
    add_random(130);
    run_phase();
    write_reg(REG_STACK_TOP, 32'hffffffff);
    write_reg(REG_STACK_SIZE, 32'd65536);
    write_reg(REG_IDLE_TOP, 32'hffffffff);
    write_reg(REG_TICK_PERIOD, 32'd1);
    add_random(130);
    run_phase();
    write_reg(REG_STACK_TOP, $urandom);
    write_reg(REG_STACK_SIZE, $urandom_range(65536, 64));
    write_reg(REG_IDLE_TOP, $urandom);
    write_reg(REG_TICK_PERIOD, $urandom_range(20, 1));
    add_random(130);
    run_phase();

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
